>>> hdl/assert_macros.svh
// assertion macros shared by the calendar conversion rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ECAL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ECAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ecal_pkg.sv
// shared types and constants for the epoch seconds to calendar conversion
`timescale 1ns / 1ps

package ecal_pkg;

    localparam int EPOCH_YEAR     = 1970;
    localparam int DAYS_PER_4Y    = 1461;
    localparam int DAYS_PER_LEAP  = 366;
    localparam int DAYS_PER_YEAR  = 365;
    localparam int SECS_PER_MIN   = 60;
    localparam int HOURS_PER_DAY  = 24;

    localparam int DAYS_W         = 16;
    localparam int YQ_W           = 8;
    localparam int DOY_W          = 9;
    localparam int ADDR_W         = 3;
    localparam int LATENCY        = 11;

    localparam logic [4:0]  OFFSET_RESET    = 5'd17;
    localparam logic        HOUR_OFFSET_IDX = 1'b0;

    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;
    localparam logic [4:0]  MDAY_LEAP     = 5'd29;
    localparam logic [4:0]  MDAY_LAST     = 5'd31;
    localparam logic [DOY_W-1:0] LEAP_DOY = 9'd60;

    // last day of year of each month, common year
    localparam logic [DOY_W-1:0] CUM_END [12] = '{
        9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    localparam logic [DOY_W-1:0] CUM_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
    } ms_t;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
    } hms_t;

    typedef struct packed {
        logic            last_day;
        logic [YQ_W-1:0] last_year;
        hms_t            hms;
    } ydc_t;

endpackage

>>> hdl/ecal_cdiv.sv
// two-stage divide by a constant: reciprocal multiply, then quotient and remainder
`timescale 1ns / 1ps

module ecal_cdiv #(
    parameter int IN_W   = 32,
    parameter int DIV    = 60,
    parameter int SIDE_W = 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [IN_W-1:0]                      x,
    input  logic [SIDE_W-1:0]                    side_in,
    output logic                                 out_valid,
    output logic [IN_W-$clog2(DIV):0]            quot,
    output logic [$clog2(DIV)-1:0]               rem,
    output logic [SIDE_W-1:0]                    side_out
);

    localparam int DB   = $clog2(DIV);
    localparam int K    = IN_W + DB;
    localparam int M_W  = IN_W + 1;
    localparam int Q_W  = IN_W - DB + 1;
    localparam int P_W  = IN_W + M_W;
    localparam longint unsigned MULT_FULL =
        ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [M_W-1:0] MULT = MULT_FULL[M_W-1:0];

    logic              va_reg;
    logic [P_W-1:0]    prod_reg;
    logic [IN_W-1:0]   x_reg;
    logic [SIDE_W-1:0] side_a_reg;

    logic              vb_reg;
    logic [Q_W-1:0]    quot_reg;
    logic [DB-1:0]     rem_reg;
    logic [SIDE_W-1:0] side_b_reg;

    logic [P_W-1:0]    prod_next;
    logic [Q_W-1:0]    quot_next;
    logic [IN_W-1:0]   rem_full;

    assign prod_next = P_W'(x) * P_W'(MULT);
    assign quot_next = prod_reg[K +: Q_W];
    assign rem_full  = x_reg - IN_W'(IN_W'(quot_next) * IN_W'(DIV));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        x_reg      <= x;
        side_a_reg <= side_in;
        quot_reg   <= quot_next;
        rem_reg    <= rem_full[DB-1:0];
        side_b_reg <= side_a_reg;
    end

    assign out_valid = vb_reg;
    assign quot      = quot_reg;
    assign rem       = rem_reg;
    assign side_out  = side_b_reg;

endmodule

>>> hdl/ecal_year.sv
// hour offset and four-year cycle handling: leap day removal and last-day detect
`timescale 1ns / 1ps

module ecal_year (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [ecal_pkg::DAYS_W-1:0] days,
    input  logic [4:0]                hour_day,
    input  ecal_pkg::ms_t             ms,
    input  logic [4:0]                hour_offset,
    output logic                      out_valid,
    output logic [ecal_pkg::DAYS_W-1:0] days_adj,
    output ecal_pkg::ydc_t            ctl
);
    import ecal_pkg::*;

    localparam int S_W    = DAYS_W + 1;
    localparam int DB4    = $clog2(DAYS_PER_4Y);
    localparam int K4     = S_W + DB4;
    localparam int M4_W   = S_W + 1;
    localparam int Q4_W   = S_W - DB4 + 1;
    localparam int P4_W   = S_W + M4_W;
    localparam int DBL    = $clog2(DAYS_PER_LEAP);
    localparam int KL     = DAYS_W + DBL;
    localparam int ML_W   = DAYS_W + 1;
    localparam int PL_W   = DAYS_W + ML_W;
    localparam longint unsigned M4_FULL =
        ((64'd1 << K4) + 64'(DAYS_PER_4Y) - 64'd1) / 64'(DAYS_PER_4Y);
    localparam longint unsigned ML_FULL =
        ((64'd1 << KL) + 64'(DAYS_PER_LEAP) - 64'd1) / 64'(DAYS_PER_LEAP);
    localparam logic [M4_W-1:0] M4 = M4_FULL[M4_W-1:0];
    localparam logic [ML_W-1:0] ML = ML_FULL[ML_W-1:0];

    logic              v1_reg;
    logic [P4_W-1:0]   prod_a_reg;
    logic [P4_W-1:0]   prod_b_reg;
    logic [PL_W-1:0]   prod_c_reg;
    logic [S_W-1:0]    s366_reg;
    logic [DAYS_W-1:0] days_reg;
    hms_t              hms_reg;

    logic              v2_reg;
    logic [DAYS_W-1:0] days_adj_reg;
    ydc_t              ctl_reg;

    logic [S_W-1:0]    s366;
    logic [S_W-1:0]    s365;
    logic [5:0]        hour_sum;
    logic [5:0]        hour_wrap;
    hms_t              hms_next;
    logic [Q4_W-1:0]   q_a;
    logic [Q4_W-1:0]   leaps;
    logic [S_W-1:0]    mod_a;
    ydc_t              ctl_next;

    assign s366 = S_W'(days) + S_W'(DAYS_PER_LEAP);
    assign s365 = S_W'(days) + S_W'(DAYS_PER_YEAR);

    // offset may be up to 31, so the sum can need two wraps
    always_comb
    begin
        hour_sum = {1'b0, hour_day} + {1'b0, hour_offset};
        if (hour_sum >= 6'(2 * HOURS_PER_DAY))
            hour_wrap = hour_sum - 6'(2 * HOURS_PER_DAY);
        else if (hour_sum >= 6'(HOURS_PER_DAY))
            hour_wrap = hour_sum - 6'(HOURS_PER_DAY);
        else
            hour_wrap = hour_sum;
        hms_next.second = ms.second;
        hms_next.minute = ms.minute;
        hms_next.hour   = hour_wrap[4:0];
    end

    assign q_a   = prod_a_reg[K4 +: Q4_W];
    assign leaps = prod_b_reg[K4 +: Q4_W];
    assign mod_a = s366_reg - S_W'(S_W'(q_a) * S_W'(DAYS_PER_4Y));

    always_comb
    begin
        ctl_next.last_day  = (mod_a == '0);
        ctl_next.last_year = prod_c_reg[KL +: YQ_W];
        ctl_next.hms       = hms_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_a_reg   <= P4_W'(s366) * P4_W'(M4);
        prod_b_reg   <= P4_W'(s365) * P4_W'(M4);
        prod_c_reg   <= PL_W'(days) * PL_W'(ML);
        s366_reg     <= s366;
        days_reg     <= days;
        hms_reg      <= hms_next;
        days_adj_reg <= days_reg - DAYS_W'(leaps);
        ctl_reg      <= ctl_next;
    end

    assign out_valid = v2_reg;
    assign days_adj  = days_adj_reg;
    assign ctl       = ctl_reg;

endmodule

>>> hdl/ecal_month.sv
// year, leap day and month lookup, output register stage
`timescale 1ns / 1ps

module ecal_month (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [ecal_pkg::YQ_W-1:0]  year_idx,
    input  logic [ecal_pkg::DOY_W-1:0] day_rem,
    input  ecal_pkg::ydc_t           ctl,
    output logic                     done,
    output logic [5:0]               second,
    output logic [5:0]               minute,
    output logic [4:0]               hour,
    output logic [4:0]               day_of_month,
    output logic [3:0]               month,
    output logic [11:0]              year
);
    import ecal_pkg::*;

    logic        done_reg;
    logic [5:0]  second_reg;
    logic [5:0]  minute_reg;
    logic [4:0]  hour_reg;
    logic [4:0]  mday_reg;
    logic [3:0]  month_reg;
    logic [11:0] year_reg;

    logic [4:0]       mday_next;
    logic [3:0]       month_next;
    logic [11:0]      year_next;
    logic [11:0]      year_norm;
    logic [11:0]      year_last;
    logic [DOY_W-1:0] doy;
    logic [DOY_W-1:0] doy_adj;
    logic [DOY_W-1:0] mday_full;
    logic             leap;
    logic [3:0]       mon_idx;

    assign year_norm = 12'(year_idx) + 12'(EPOCH_YEAR);
    assign year_last = 12'(ctl.last_year) + 12'(EPOCH_YEAR);
    assign doy       = day_rem + 9'd1;
    assign leap      = (year_norm[1:0] == 2'b00);

    always_comb
    begin
        doy_adj = (leap && doy > LEAP_DOY) ? doy - 9'd1 : doy;
        // first month whose end is not before the day, december if none
        mon_idx = 4'd11;
        for (int i = 10; i >= 0; i--)
        begin
            if (CUM_END[i] >= doy_adj)
                mon_idx = 4'(i);
        end
        mday_full = doy_adj - CUM_START[mon_idx];

        if (ctl.last_day)
        begin
            year_next  = year_last;
            month_next = MONTH_DEC;
            mday_next  = MDAY_LAST;
        end
        else if (leap && doy == LEAP_DOY)
        begin
            year_next  = year_norm;
            month_next = MONTH_FEB;
            mday_next  = MDAY_LEAP;
        end
        else
        begin
            year_next  = year_norm;
            month_next = mon_idx + 4'd1;
            mday_next  = mday_full[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        second_reg <= ctl.hms.second;
        minute_reg <= ctl.hms.minute;
        hour_reg   <= ctl.hms.hour;
        mday_reg   <= mday_next;
        month_reg  <= month_next;
        year_reg   <= year_next;
    end

    assign done         = done_reg;
    assign second       = second_reg;
    assign minute       = minute_reg;
    assign hour         = hour_reg;
    assign day_of_month = mday_reg;
    assign month        = month_reg;
    assign year         = year_reg;

endmodule

>>> hdl/epoch_seconds_to_calendar_unit.sv
// top level: register port and the conversion pipeline
//
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into second,
// minute, hour, day of month, month and year (plain four-year leap rule).
// Request channel: drive epoch_seconds and pulse start; busy is always low,
// so a request is taken in every cycle that start is high.
// Result channel: done is high for one cycle with the result fields; the
// receiver cannot hold results off and none is needed.
// Throughput is one request per cycle; the stages are three reciprocal-multiply
// dividers (by 60, 60, 24), the four-year cycle stage pair, the divide by 365
// and the month lookup stage, each multiply followed by a register.
// Register hour_offset (byte address 0, reset 17) is added to the hour
// modulo 24; the date is not shifted. Write it only with no request in flight.
// Reset clears all stage valid bits and loads hour_offset with 17.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [31:0]                 epoch_seconds,
    output logic                        done,
    output logic [5:0]                  second,
    output logic [5:0]                  minute,
    output logic [4:0]                  hour,
    output logic [4:0]                  day_of_month,
    output logic [3:0]                  month,
    output logic [11:0]                 year,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ecal_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ecal_pkg::*;

    `include "assert_macros.svh"

    logic [4:0]  hour_offset_reg;
    logic        cfg_write;
    logic        req_accept;

    logic        v_min;
    logic [26:0] q_min;
    logic [5:0]  r_sec;

    logic        v_hr;
    logic [21:0] q_hr;
    logic [5:0]  r_min;
    logic [5:0]  sec_d1;

    logic        v_day;
    logic [17:0] q_day;
    logic [4:0]  r_hour;
    ms_t         ms_d2;
    ms_t         ms_side;

    logic        v_year;
    logic [DAYS_W-1:0] days_adj;
    ydc_t        ctl_year;

    logic        v_doy;
    logic [YQ_W-1:0]  year_idx;
    logic [DOY_W-1:0] day_rem;
    ydc_t        ctl_doy;

    assign busy       = 1'b0;
    assign pready     = 1'b1;
    assign req_accept = start && !busy;
    assign cfg_write  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hour_offset_reg <= OFFSET_RESET;
        else if (cfg_write && paddr[2] == HOUR_OFFSET_IDX)
            hour_offset_reg <= pwdata[4:0];
    end

    assign prdata = (paddr[2] == HOUR_OFFSET_IDX) ? {27'd0, hour_offset_reg} : 32'd0;

    ecal_cdiv #(.IN_W(32), .DIV(SECS_PER_MIN), .SIDE_W(1)) u_div_sec (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_accept),
        .x         (epoch_seconds),
        .side_in   (1'b0),
        .out_valid (v_min),
        .quot      (q_min),
        .rem       (r_sec),
        .side_out  ()
    );

    ecal_cdiv #(.IN_W(27), .DIV(SECS_PER_MIN), .SIDE_W(6)) u_div_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_min),
        .x         (q_min),
        .side_in   (r_sec),
        .out_valid (v_hr),
        .quot      (q_hr),
        .rem       (r_min),
        .side_out  (sec_d1)
    );

    assign ms_side.second = sec_d1;
    assign ms_side.minute = r_min;

    ecal_cdiv #(.IN_W(22), .DIV(HOURS_PER_DAY), .SIDE_W($bits(ms_t))) u_div_hour (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_hr),
        .x         (q_hr),
        .side_in   (ms_side),
        .out_valid (v_day),
        .quot      (q_day),
        .rem       (r_hour),
        .side_out  (ms_d2)
    );

    ecal_year u_year (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (v_day),
        .days        (q_day[DAYS_W-1:0]),
        .hour_day    (r_hour),
        .ms          (ms_d2),
        .hour_offset (hour_offset_reg),
        .out_valid   (v_year),
        .days_adj    (days_adj),
        .ctl         (ctl_year)
    );

    ecal_cdiv #(.IN_W(DAYS_W), .DIV(DAYS_PER_YEAR), .SIDE_W($bits(ydc_t))) u_div_year (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_year),
        .x         (days_adj),
        .side_in   (ctl_year),
        .out_valid (v_doy),
        .quot      (year_idx),
        .rem       (day_rem),
        .side_out  (ctl_doy)
    );

    ecal_month u_month (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (v_doy),
        .year_idx     (year_idx),
        .day_rem      (day_rem),
        .ctl          (ctl_doy),
        .done         (done),
        .second       (second),
        .minute       (minute),
        .hour         (hour),
        .day_of_month (day_of_month),
        .month        (month),
        .year         (year)
    );

    // every result traces back to an accepted request
    `ECAL_ASSERT_IMPLY(a_done_latency, clk, rst_n, done, $past(req_accept, LATENCY), "done without matching request")
    `ECAL_ASSERT_IMPLY(a_time_range, clk, rst_n, done, second < 6'd60 && minute < 6'd60 && hour < 5'd24, "time field out of range")
    `ECAL_ASSERT_IMPLY(a_date_range, clk, rst_n, done, month >= 4'd1 && month <= MONTH_DEC && day_of_month != 5'd0 && year >= 12'(EPOCH_YEAR), "date field out of range")
    `ECAL_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_write && paddr[2] == HOUR_OFFSET_IDX, hour_offset_reg == $past(pwdata[4:0]), "hour offset write lost")

endmodule
